// ----- rtl/bfb_pkg.sv -----
// ----------------------------------------------------------------------------
// bfb_pkg: shared types and constants of the ball step unit
// Field widths, register indexes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package bfb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_FRICTION    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RESTITUTION = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FIELD_WIDTH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FIELD_LEN   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BALL_DIAM   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MARGIN_X    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MARGIN_Y    = 3'd6;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_PLACE   = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [15:0]        time_step;
    logic               ball_held;
    logic [15:0]        place_pos_x;
    logic [15:0]        place_pos_y;
    logic signed [15:0] place_vel_x;
    logic signed [15:0] place_vel_y;
  } tick_word_t;

  typedef struct packed {
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } ball_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_SQRT,
    ST_SCALE,
    ST_DIV,
    ST_MOVE,
    ST_WALL,
    ST_BOUNCE,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/bfb_if.sv -----
// ----------------------------------------------------------------------------
// bfb_if: valid/ready channel carrying one word of type T
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface bfb_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ball_friction_bounce_step_unit.sv -----
// ----------------------------------------------------------------------------
// ball_friction_bounce_step_unit: one 2D ball, friction, motion and bounce
// Sequencer around one shared 17x17 multiplier, a bit-serial square root and
// a bit-serial divider.
// ----------------------------------------------------------------------------
// Use: the tick channel takes a place word (load position and velocity) or
// an advance word (move by time_step unless ball_held). Every tick word gives
// one ball word on the result channel holding the state after the word.
// The user is to make configuration writes (cfg_we, cfg_index, cfg_data) while
// idle; the unit itself does not enforce this. A place word or a held advance
// goes straight to the output step; a moving advance takes 2 square steps, 16
// square root steps, one friction step, per velocity axis a load and 32 divide
// steps, per axis a motion and a wall step plus one restitution step on a
// bounce, and one output step; a ball at rest skips the divide steps. One word
// is in work at a time; tick.ready is high only when idle, so a new tick word
// is taken in the cycle after the ball word is loaded.
// Reset clears the ball state to zero and the registers to their defaults.
// A stalled result holds in the output register; the next result waits in
// the unit until it is taken.
// ----------------------------------------------------------------------------
module ball_friction_bounce_step_unit (
  input  logic                             clk,
  input  logic                             rst,
  bfb_if.sink                              tick,
  bfb_if.source                            ball,
  input  logic                             cfg_we,
  input  logic [bfb_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bfb_pkg::CfgDataW-1:0]     cfg_data
);

  // configuration registers
  logic [15:0] friction, restitution;
  logic [11:0] field_width, field_length, ball_diameter;
  logic [9:0]  margin_x, margin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      friction      <= 16'd0;
      restitution   <= 16'd32768;
      field_width   <= 12'd800;
      field_length  <= 12'd600;
      ball_diameter <= 12'd400;
      margin_x      <= 10'd45;
      margin_y      <= 10'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        bfb_pkg::REG_FRICTION:    friction      <= cfg_data;
        bfb_pkg::REG_RESTITUTION: restitution   <= cfg_data;
        bfb_pkg::REG_FIELD_WIDTH: field_width   <= cfg_data[11:0];
        bfb_pkg::REG_FIELD_LEN:   field_length  <= cfg_data[11:0];
        bfb_pkg::REG_BALL_DIAM:   ball_diameter <= cfg_data[11:0];
        bfb_pkg::REG_MARGIN_X:    margin_x      <= cfg_data[9:0];
        bfb_pkg::REG_MARGIN_Y:    margin_y      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  bfb_pkg::state_t state, state_next;

  // ball state and work registers
  logic [15:0]        pos_x, pos_y;
  logic signed [15:0] vel_x, vel_y;
  logic [15:0]        dt;
  logic [31:0]        sq;          // vx^2 + vy^2, then shifted out two bits per root step
  logic [15:0]        root;
  logic [5:0]         cnt;
  logic               axis;        // 0 x, 1 y
  logic [16:0]        speed, ns;
  logic [32:0]        quot;        // dividend shifts out, quotient shifts in
  logic [16:0]        rem;
  logic signed [17:0] pos_w;       // wide position under check
  logic signed [15:0] v_cur;       // velocity of the axis being worked
  logic signed [17:0] v_bnc;
  logic               load_out;

  // shared multiplier: unsigned 17 x unsigned 17
  logic [16:0] mul_m;
  logic [16:0] mul_b;

  logic [16:0] v_mag;
  assign v_mag = v_cur[15] ? 17'(-{v_cur[15], v_cur}) : {1'b0, v_cur};

  // magnitude product, truncated shifts toward zero
  logic [33:0] mag_p;
  assign mag_p = 34'(mul_m) * 34'(mul_b);

  always_comb begin
    mul_m = (state == bfb_pkg::ST_SCALE) ? {1'b0, dt} : v_mag;
    mul_b = v_mag;
    case (state)
      bfb_pkg::ST_SCALE:  mul_b = {1'b0, friction};
      bfb_pkg::ST_DIV:    mul_b = ns;
      bfb_pkg::ST_MOVE:   mul_b = {1'b0, dt};
      bfb_pkg::ST_BOUNCE: mul_b = {1'b0, restitution};
      default: ;
    endcase
  end

  // square root step (two bits per step, 16 steps over 32 bits)
  logic [18:0] sq_trial;
  logic [18:0] sq_rem2;
  logic        sq_ge;
  assign sq_rem2  = {rem, sq[31:30]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = (sq_rem2 >= sq_trial);

  // divide step
  logic [17:0] d_rem;
  logic        d_ge;
  assign d_rem = {rem, quot[32]};
  assign d_ge  = (d_rem >= {1'b0, speed});

  // wall limits
  logic signed [17:0] near_w, far_w;
  logic [11:0] fld;
  logic [9:0]  mrg;
  assign fld    = axis ? field_length : field_width;
  assign mrg    = axis ? margin_y : margin_x;
  assign near_w = 18'({mrg, 4'd0});
  assign far_w  = 18'({fld, 4'd0}) - 18'({mrg, 4'd0}) - 18'(ball_diameter);

  logic signed [15:0] v_sat;
  assign v_sat = (v_bnc > 18'sd32767) ? 16'sd32767 :
                 (v_bnc < -18'sd32768) ? -16'sd32768 : v_bnc[15:0];

  always_ff @(posedge clk) begin
    if (rst) state <= bfb_pkg::ST_IDLE;
    else     state <= state_next;
  end

  logic hit;
  assign hit = (pos_w <= near_w) || (pos_w >= far_w);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfb_pkg::ST_IDLE:
        if (tick.valid) begin
          if (tick.data.operation == bfb_pkg::OP_PLACE || tick.data.ball_held)
            state_next = bfb_pkg::ST_DONE;
          else
            state_next = bfb_pkg::ST_SQR;
        end
      bfb_pkg::ST_SQR:    if (axis) state_next = bfb_pkg::ST_SQRT;
      bfb_pkg::ST_SQRT:   if (cnt == 6'd15) state_next = bfb_pkg::ST_SCALE;
      bfb_pkg::ST_SCALE:
        state_next = (root == 16'd0) ? bfb_pkg::ST_MOVE : bfb_pkg::ST_DIV;
      bfb_pkg::ST_DIV:
        if (cnt == 6'd32 && axis) state_next = bfb_pkg::ST_MOVE;
      bfb_pkg::ST_MOVE:   state_next = bfb_pkg::ST_WALL;
      bfb_pkg::ST_WALL:   state_next = hit ? bfb_pkg::ST_BOUNCE :
                                       (axis ? bfb_pkg::ST_DONE : bfb_pkg::ST_MOVE);
      bfb_pkg::ST_BOUNCE: state_next = axis ? bfb_pkg::ST_DONE : bfb_pkg::ST_MOVE;
      bfb_pkg::ST_DONE:   if (!ball.valid || ball.ready) state_next = bfb_pkg::ST_IDLE;
      default:            state_next = bfb_pkg::ST_IDLE;
    endcase
  end

  assign tick.ready = (state == bfb_pkg::ST_IDLE);
  assign load_out   = (state == bfb_pkg::ST_DONE) && (!ball.valid || ball.ready);

  // velocity of the working axis
  assign v_cur = axis ? vel_y : vel_x;

  // quotient including the bit of the last divide step
  logic [16:0] q_mag;
  logic signed [16:0] q_sgn;
  assign q_mag = {quot[15:0], d_ge};
  assign q_sgn = v_cur[15] ? -$signed(q_mag) : $signed(q_mag);

  logic signed [17:0] delta;
  assign delta = v_cur[15] ? -$signed({1'b0, mag_p[32:16]}) : $signed({1'b0, mag_p[32:16]});

  logic [15:0] pos_sat;
  assign pos_sat = (pos_w < 0) ? 16'd0 : (pos_w > 18'sd65535) ? 16'hFFFF : pos_w[15:0];

  logic signed [17:0] wall_pos;
  assign wall_pos = (pos_w <= near_w) ? near_w : (pos_w >= far_w) ? far_w : pos_w;

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= 16'd0;
      pos_y <= 16'd0;
      vel_x <= 16'sd0;
      vel_y <= 16'sd0;
      axis  <= 1'b0;
      cnt   <= 6'd0;
    end else begin
      case (state)
        bfb_pkg::ST_IDLE: if (tick.valid) begin
          dt   <= tick.data.time_step;
          axis <= 1'b0;
          sq   <= 32'd0;
          if (tick.data.operation == bfb_pkg::OP_PLACE) begin
            pos_x <= tick.data.place_pos_x;
            pos_y <= tick.data.place_pos_y;
            vel_x <= tick.data.place_vel_x;
            vel_y <= tick.data.place_vel_y;
          end
        end
        bfb_pkg::ST_SQR: begin
          // accumulate squares, one axis per cycle
          sq   <= sq + 32'(mag_p);
          axis <= ~axis;
          cnt  <= 6'd0;
          root <= 16'd0;
          rem  <= 17'd0;
        end
        bfb_pkg::ST_SQRT: begin
          // one result bit per step
          if (sq_ge) begin
            rem  <= 17'(sq_rem2 - sq_trial);
            root <= {root[14:0], 1'b1};
          end else begin
            rem  <= sq_rem2[16:0];
            root <= {root[14:0], 1'b0};
          end
          sq  <= {sq[29:0], 2'b00};
          cnt <= cnt + 6'd1;
        end
        bfb_pkg::ST_SCALE: begin
          // friction drop and new speed
          speed <= {1'b0, root};
          ns    <= ({1'b0, root} > 17'(mag_p[31:16])) ?
                   17'({1'b0, root} - 17'(mag_p[31:16])) : 17'd0;
          axis  <= 1'b0;
          cnt   <= 6'd0;
          rem   <= 17'd0;
          quot  <= 33'd0;
        end
        bfb_pkg::ST_DIV: begin
          // first cycle of an axis loads |v|*ns, then one quotient bit per cycle
          if (cnt == 6'd0) begin
            quot <= {mag_p[31:0], 1'b0};
            rem  <= 17'd0;
            cnt  <= 6'd1;
          end else begin
            rem  <= d_ge ? 17'(d_rem - {1'b0, speed}) : d_rem[16:0];
            quot <= {quot[31:0], d_ge};
            cnt  <= cnt + 6'd1;
            if (cnt == 6'd32) begin
              if (axis) vel_y <= q_sgn[15:0]; else vel_x <= q_sgn[15:0];
              axis <= ~axis;
              cnt  <= 6'd0;
            end
          end
        end
        bfb_pkg::ST_MOVE: begin
          pos_w <= 18'(axis ? pos_y : pos_x) + delta;
        end
        bfb_pkg::ST_WALL: begin
          pos_w <= wall_pos;
          if (!hit) begin
            if (axis) pos_y <= pos_sat; else pos_x <= pos_sat;
            axis <= ~axis;
          end
        end
        bfb_pkg::ST_BOUNCE: begin
          if (axis) begin
            vel_y <= v_sat; pos_y <= pos_sat;
          end else begin
            vel_x <= v_sat; pos_x <= pos_sat;
          end
          axis <= ~axis;
        end
        default: ;
      endcase
    end
  end

  // bounce velocity from the shared multiplier magnitude
  assign v_bnc = v_cur[15] ? $signed({1'b0, mag_p[31:15]}) :
                 -$signed({1'b0, mag_p[31:15]});

  // output register
  always_ff @(posedge clk) begin
    if (rst) ball.valid <= 1'b0;
    else if (load_out) ball.valid <= 1'b1;
    else if (ball.ready) ball.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ball.data.pos_x <= pos_x;
      ball.data.pos_y <= pos_y;
      ball.data.vel_x <= vel_x;
      ball.data.vel_y <= vel_y;
    end
  end

endmodule

// ----- bench/ball_friction_bounce_step_unit_tb.sv -----
// ----------------------------------------------------------------------------
// ball_friction_bounce_step_unit_tb: self-checking bench of the ball step unit
// Drives place and advance words through the tick channel with random gaps,
// stalls the ball channel at random, and checks every ball word against a
// fixed-point motion predictor that tracks ball state and registers.
// ----------------------------------------------------------------------------
module ball_friction_bounce_step_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [bfb_pkg::CfgIdxW-1:0]  cfg_index;
  logic [bfb_pkg::CfgDataW-1:0] cfg_data;

  bfb_if #(.T(bfb_pkg::tick_word_t)) tick_ch ();
  bfb_if #(.T(bfb_pkg::ball_word_t)) ball_ch ();

  ball_friction_bounce_step_unit dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .ball      (ball_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of registers and ball state
  longint unsigned m_friction, m_restitution, m_field_w, m_field_l;
  longint unsigned m_diam, m_margin_x, m_margin_y;
  longint          m_pos_x, m_pos_y, m_vel_x, m_vel_y;

  bfb_pkg::tick_word_t tick_pending[$];
  bfb_pkg::ball_word_t ball_expected[$];
  int                  mismatches;
  int                  max_gap;
  bit                  tick_busy, tick_took, ball_took;
  int                  tick_gap, ball_stall;
  bfb_pkg::tick_word_t tick_cur;

  always #10 clk = ~clk;

  function automatic longint sat_vel(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > 65535) return 65535;
    if (v < 0) return 0;
    return v;
  endfunction

  // a * b >> sh, truncated toward zero
  function automatic longint scale_shift(longint a, longint unsigned b, int sh);
    longint unsigned mag;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    mag = (mag * b) >> sh;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // a * n / d, truncated toward zero
  function automatic longint scale_ratio(longint a, longint unsigned n,
                                         longint unsigned d);
    longint unsigned mag;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    mag = (mag * n) / d;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Clamp at a wall pair and reflect the velocity
  function automatic void wall_axis(inout longint pos, inout longint vel,
                                    input longint unsigned field,
                                    input longint unsigned margin);
    longint near_w, far_w;
    near_w = longint'(margin) * 16;
    far_w  = longint'(field) * 16 - longint'(margin) * 16 - longint'(m_diam);
    if (pos <= near_w) begin
      vel = sat_vel(-scale_shift(vel, m_restitution, 15));
      pos = near_w;
    end else if (pos >= far_w) begin
      vel = sat_vel(-scale_shift(vel, m_restitution, 15));
      pos = far_w;
    end
  endfunction

  function automatic bfb_pkg::ball_word_t advance_ball(bfb_pkg::tick_word_t t);
    bfb_pkg::ball_word_t r;
    longint              vx, vy, px, py;
    longint unsigned     spd, drop, ns;
    if (t.operation == bfb_pkg::OP_PLACE) begin
      m_pos_x = t.place_pos_x;
      m_pos_y = t.place_pos_y;
      m_vel_x = t.place_vel_x;
      m_vel_y = t.place_vel_y;
    end else if (!t.ball_held) begin
      vx  = m_vel_x;
      vy  = m_vel_y;
      spd = floor_root(longint'(vx * vx + vy * vy));
      if (spd > 0) begin
        drop = (m_friction * t.time_step) >> 16;
        ns   = (spd > drop) ? spd - drop : 0;
        vx   = scale_ratio(vx, ns, spd);
        vy   = scale_ratio(vy, ns, spd);
      end
      px = m_pos_x + scale_shift(vx, t.time_step, 16);
      py = m_pos_y + scale_shift(vy, t.time_step, 16);
      wall_axis(px, vx, m_field_w, m_margin_x);
      wall_axis(py, vy, m_field_l, m_margin_y);
      m_pos_x = sat_pos(px);
      m_pos_y = sat_pos(py);
      m_vel_x = vx;
      m_vel_y = vy;
    end
    r.pos_x = m_pos_x[15:0];
    r.pos_y = m_pos_y[15:0];
    r.vel_x = m_vel_x[15:0];
    r.vel_y = m_vel_y[15:0];
    return r;
  endfunction

  // Drive tick words and ball ready on the falling edge
  always @(negedge clk) begin
    if (tick_busy && tick_took) begin
      tick_busy = 0;
      tick_gap  = $urandom_range(0, max_gap);
    end
    tick_took = 0;
    if (!tick_busy && tick_pending.size() > 0) begin
      if (tick_gap == 0) begin
        tick_cur  = tick_pending.pop_front();
        tick_busy = 1;
      end else begin
        tick_gap--;
      end
    end
    tick_ch.valid <= tick_busy;
    tick_ch.data  <= tick_cur;

    if (ball_took) ball_stall = $urandom_range(0, max_gap);
    ball_took = 0;
    if (ball_stall > 0) begin
      ball_stall--;
      ball_ch.ready <= 1'b0;
    end else begin
      ball_ch.ready <= 1'b1;
    end
  end

  // Predict on accepted tick words, check accepted ball words
  always @(posedge clk) begin
    bfb_pkg::ball_word_t want, got;
    if (!rst && tick_ch.valid && tick_ch.ready) begin
      ball_expected.push_back(advance_ball(tick_ch.data));
      tick_took = 1;
    end
    if (!rst && ball_ch.valid && ball_ch.ready) begin
      ball_took = 1;
      got = ball_ch.data;
      if (ball_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected ball word %h", got);
      end else begin
        want = ball_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ball word mismatch: expected pos %0d,%0d vel %0d,%0d got %0d,%0d vel %0d,%0d",
                     want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                     got.pos_x, got.pos_y, got.vel_x, got.vel_y);
        end
      end
    end
  end

  task automatic write_reg(logic [bfb_pkg::CfgIdxW-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    case (idx)
      bfb_pkg::REG_FRICTION:    m_friction    = value & 16'hFFFF;
      bfb_pkg::REG_RESTITUTION: m_restitution = value & 16'hFFFF;
      bfb_pkg::REG_FIELD_WIDTH: m_field_w     = value & 12'hFFF;
      bfb_pkg::REG_FIELD_LEN:   m_field_l     = value & 12'hFFF;
      bfb_pkg::REG_BALL_DIAM:   m_diam        = value & 12'hFFF;
      bfb_pkg::REG_MARGIN_X:    m_margin_x    = value & 10'h3FF;
      bfb_pkg::REG_MARGIN_Y:    m_margin_y    = value & 10'h3FF;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned fr, int unsigned rs, int unsigned fw,
                           int unsigned fl, int unsigned bd, int unsigned mx,
                           int unsigned my);
    write_reg(bfb_pkg::REG_FRICTION, fr);
    write_reg(bfb_pkg::REG_RESTITUTION, rs);
    write_reg(bfb_pkg::REG_FIELD_WIDTH, fw);
    write_reg(bfb_pkg::REG_FIELD_LEN, fl);
    write_reg(bfb_pkg::REG_BALL_DIAM, bd);
    write_reg(bfb_pkg::REG_MARGIN_X, mx);
    write_reg(bfb_pkg::REG_MARGIN_Y, my);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bfb_pkg::tick_word_t make_tick(logic op, int unsigned dt,
                                                    logic held,
                                                    int unsigned px, int unsigned py,
                                                    int vx, int vy);
    bfb_pkg::tick_word_t t;
    t.operation   = op;
    t.time_step   = dt[15:0];
    t.ball_held   = held;
    t.place_pos_x = px[15:0];
    t.place_pos_y = py[15:0];
    t.place_vel_x = vx[15:0];
    t.place_vel_y = vy[15:0];
    return t;
  endfunction

  // Hold until every queued word went through and its result arrived
  task automatic drain();
    while (tick_pending.size() > 0 || tick_busy || ball_expected.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // One random flight: place inside the field, then a run of advances
  task automatic queue_flight();
    int unsigned n, dt_max;
    n = $urandom_range(3, 20);
    dt_max = ($urandom_range(0, 3) == 0) ? 65535 : 6000;
    tick_pending.push_back(make_tick(bfb_pkg::OP_PLACE, $urandom, 1'($urandom),
        $urandom_range(0, 32'((m_field_w * 16 > 65535) ? 65535 : m_field_w * 16)),
        $urandom_range(0, 32'((m_field_l * 16 > 65535) ? 65535 : m_field_l * 16)),
        int'($urandom_range(0, 65535)) - 32768,
        int'($urandom_range(0, 65535)) - 32768));
    repeat (n)
      tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, $urandom_range(0, dt_max),
          $urandom_range(0, 9) == 0, $urandom, $urandom, $urandom, $urandom));
  endtask

  initial begin
    int phase, sent;
    clk = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    tick_ch.valid = 0;
    tick_ch.data = '0;
    ball_ch.ready = 0;
    tick_busy = 0; tick_took = 0; ball_took = 0;
    tick_gap = 0; ball_stall = 0;
    tick_cur = '0;
    mismatches = 0;
    max_gap = 17;
    m_friction = 0; m_restitution = 32768; m_field_w = 800; m_field_l = 600;
    m_diam = 400; m_margin_x = 45; m_margin_y = 30;
    m_pos_x = 0; m_pos_y = 0; m_vel_x = 0; m_vel_y = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, held ball, zero step, field corners
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_PLACE, 0, 1, 6000, 4000, 500, -300));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 1, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_PLACE, 0, 0, 65535, 65535, 32767, 32767));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_PLACE, 0, 0, 0, 0, -32768, -32768));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 1, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    drain();

    // Directed: maximal friction and restitution, degenerate field
    write_all(65535, 65535, 0, 4095, 4095, 1023, 0);
    tick_pending.push_back(make_tick(bfb_pkg::OP_PLACE, 0, 0, 30000, 100, -32768, 32767));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 100, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_PLACE, 0, 0, 100, 60000, 32767, -32768));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 20, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    drain();
    write_all(0, 0, 4095, 0, 0, 0, 1023);
    tick_pending.push_back(make_tick(bfb_pkg::OP_PLACE, 0, 0, 500, 500, 20000, -20000));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    tick_pending.push_back(make_tick(bfb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    drain();

    // Random phases over a spread of settings
    sent = 0;
    phase = 0;
    while (sent < 1750) begin
      max_gap = (phase % 4 == 3) ? 0 : 17;
      case (phase % 4)
        0: write_all(0, 32768, 800, 600, 400, 45, 30);
        1: write_all($urandom_range(0, 65535), $urandom_range(0, 32768),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
        2: write_all($urandom_range(0, 3000), $urandom_range(16000, 65535),
                     $urandom_range(100, 1000), $urandom_range(100, 1000),
                     $urandom_range(0, 800), $urandom_range(0, 60),
                     $urandom_range(0, 60));
        default: write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
      endcase
      repeat (10) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: arbitrary words of either kind
          repeat (4) tick_pending.push_back(make_tick(1'($urandom), $urandom,
              1'($urandom), $urandom, $urandom, $urandom, $urandom));
        end else begin
          queue_flight();
        end
      end
      sent += tick_pending.size();
      drain();
      phase++;
    end

    if (mismatches == 0 && ball_expected.size() == 0) begin
      $display("PASS ball_friction_bounce_step_unit");
    end else begin
      $display("FAIL ball_friction_bounce_step_unit");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAIL ball_friction_bounce_step_unit");
    $finish;
  end

endmodule
